// File: src/psm_pkg.sv
package psm_pkg;

   // Voice slots and per-voice store capacity
   localparam int VOICES      = 8;
   localparam int SOUND_DEPTH = 4096;

   localparam int SLOT_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int POS_W       = $clog2(SOUND_DEPTH + 1);
   localparam int STORE_DEPTH = VOICES * SOUND_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int SAMPLE_W    = 16;
   localparam int SLOT_OUT_W  = 3;

   // Q2.14 clamp limits, one bit wider than a sample to hold a raw sum
   localparam logic signed [SAMPLE_W:0] POS_ONE = 17'sd16384;
   localparam logic signed [SAMPLE_W:0] NEG_ONE = -17'sd16384;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_TICK   = 1'b1;
   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef struct packed {
      logic clear;
      logic add;
   } accum_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

// File: src/psm_req_if.sv
interface psm_req_if;
   import psm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;

   modport source (output valid, cmd, sample, last, input ready);
   modport sink   (input valid, cmd, sample, last, output ready);
endinterface

// File: src/psm_rsp_if.sv
interface psm_rsp_if;
   import psm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic signed [SAMPLE_W-1:0] mixed;
   logic [SLOT_OUT_W-1:0]      slot;
   logic                       truncated;

   modport source (output valid, kind, mixed, slot, truncated, input ready);
   modport sink   (input valid, kind, mixed, slot, truncated, output ready);
endinterface

// File: src/psm_ram.sv
module psm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/psm_accum.sv
module psm_accum (
   input  logic                                clock,
   input  psm_pkg::accum_ctl_type              ctl,
   input  logic signed [psm_pkg::SAMPLE_W-1:0] sample,
   output logic signed [psm_pkg::SAMPLE_W-1:0] acc
);
   import psm_pkg::*;

   logic signed [SAMPLE_W-1:0] acc_ff;
   logic signed [SAMPLE_W-1:0] acc_in;
   logic signed [SAMPLE_W:0]   sum;

   // Clear, or add and then saturate to plus or minus one
   always_comb begin
      sum = {acc_ff[SAMPLE_W-1], acc_ff} + {sample[SAMPLE_W-1], sample};
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.add) begin
         if (sum > POS_ONE) begin
            acc_in = POS_ONE[SAMPLE_W-1:0];
         end else if (sum < NEG_ONE) begin
            acc_in = NEG_ONE[SAMPLE_W-1:0];
         end else begin
            acc_in = sum[SAMPLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: src/polyphonic_sample_mixer_core.sv
// Polyphonic sample mixer. Each transfer on req_chan is either a load (one
// sample of a sound, with last marking its end) or a tick (one mixed frame);
// every transfer gives exactly one transfer on rsp_chan. The first sample of
// a sound claims the first idle voice searching round-robin from a rotating
// pointer, or steals the voice at the pointer when all are playing; that
// voice is silenced until its last sample arrives. Samples past the per-voice
// store depth are dropped and flagged as truncated. A tick walks the voices
// in index order through one shared add-and-clamp accumulator, saturating to
// +/-1.0 (Q2.14) after each addition, and retires voices that run out.
// Sequence: a load goes through the load and done states. A tick visits the
// voices in the check state, with an add state after the check for each sounding
// voice, then the done state: each sounding voice needs one registered read of the
// sample store and one pass through the accumulator. The next request is
// taken as soon as the previous result sits in the output register.
module polyphonic_sample_mixer_core (
   input  logic       clock,
   input  logic       reset,
   psm_req_if.sink    req_chan,
   psm_rsp_if.source  rsp_chan
);
   import psm_pkg::*;

   // ---------------------------------------------------------------- state
   state_type                  state_ff, state_in;
   logic                       cmd_ff, cmd_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       last_ff, last_in;

   logic [POS_W-1:0]           len_ff [VOICES];
   logic [POS_W-1:0]           len_in [VOICES];
   logic [POS_W-1:0]           pos_ff [VOICES];
   logic [POS_W-1:0]           pos_in [VOICES];
   logic [VOICES-1:0]          active_ff, active_in;
   logic [SLOT_W-1:0]          next_slot_ff, next_slot_in;
   logic                       load_open_ff, load_open_in;
   logic [SLOT_W-1:0]          load_slot_ff, load_slot_in;
   logic [SLOT_W-1:0]          voice_ff, voice_in;

   logic [SLOT_W-1:0]          res_slot_ff, res_slot_in;
   logic                       res_trunc_ff, res_trunc_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic signed [SAMPLE_W-1:0] rsp_mixed_ff, rsp_mixed_in;
   logic [SLOT_OUT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                       rsp_trunc_ff, rsp_trunc_in;

   // ------------------------------------------------------------ datapath
   logic [SLOT_W-1:0]          pick_slot;
   logic                       pick_found;
   logic [SLOT_W:0]            pick_idx;
   logic [SLOT_W-1:0]          cur_slot;
   logic [POS_W-1:0]           cur_len;
   logic [POS_W-1:0]           cur_pos;
   logic [POS_W-1:0]           len_eff;
   logic [POS_W-1:0]           len_new;
   logic [POS_W-1:0]           pos_next;
   logic                       store_room;
   logic                       has_data;
   logic                       last_voice;
   logic                       out_free;

   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic                       ram_rd_en;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic [SAMPLE_W-1:0]        ram_rd_data;

   accum_ctl_type              acc_ctl;
   logic signed [SAMPLE_W-1:0] acc_value;

   // Round-robin search for the first idle voice from the pointer; fall back
   // to stealing the voice at the pointer
   always_comb begin
      pick_slot  = next_slot_ff;
      pick_found = 1'b0;
      pick_idx   = '0;
      for (int i = 0; i < VOICES; i++) begin
         pick_idx = (SLOT_W+1)'(next_slot_ff) + (SLOT_W+1)'(i);
         if (pick_idx >= (SLOT_W+1)'(VOICES)) begin
            pick_idx = pick_idx - (SLOT_W+1)'(VOICES);
         end
         if (!pick_found && !active_ff[pick_idx[SLOT_W-1:0]]) begin
            pick_slot  = pick_idx[SLOT_W-1:0];
            pick_found = 1'b1;
         end
      end
   end

   // One voice is touched per cycle: the slot being loaded, or the voice
   // that the tick walk has reached
   always_comb begin
      if (state_ff == ST_LOAD) begin
         cur_slot = load_open_ff ? load_slot_ff : pick_slot;
      end else begin
         cur_slot = voice_ff;
      end
      cur_len    = len_ff[cur_slot];
      cur_pos    = pos_ff[cur_slot];
      len_eff    = load_open_ff ? cur_len : '0;
      store_room = len_eff < POS_W'(SOUND_DEPTH);
      len_new    = store_room ? len_eff + POS_W'(1) : len_eff;
      pos_next   = cur_pos + POS_W'(1);
      has_data   = active_ff[cur_slot] && (cur_pos < cur_len) &&
                   (cur_pos < POS_W'(SOUND_DEPTH));
      last_voice = voice_ff == SLOT_W'(VOICES - 1);
      out_free   = !rsp_valid_ff || rsp_chan.ready;
   end

   assign ram_wr_addr = ADDR_W'(cur_slot * SOUND_DEPTH) + ADDR_W'(len_eff);
   assign ram_rd_addr = ADDR_W'(cur_slot * SOUND_DEPTH) + ADDR_W'(cur_pos);

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      active_in    = active_ff;
      next_slot_in = next_slot_ff;
      load_open_in = load_open_ff;
      load_slot_in = load_slot_ff;
      voice_in     = voice_ff;
      res_slot_in  = res_slot_ff;
      res_trunc_in = res_trunc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_mixed_in = rsp_mixed_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_trunc_in = rsp_trunc_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      acc_ctl      = '0;

      // Drop the held result once the sink takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in       = req_chan.cmd;
               sample_in    = req_chan.sample;
               last_in      = req_chan.last;
               voice_in     = '0;
               res_slot_in  = '0;
               res_trunc_in = 1'b0;
               acc_ctl.clear = 1'b1;
               state_in     = (req_chan.cmd == CMD_TICK) ? ST_CHECK : ST_LOAD;
            end
         end

         ST_LOAD: begin
            // Opening a sound claims the slot and silences it
            if (!load_open_ff) begin
               load_slot_in = pick_slot;
               next_slot_in = (pick_slot == SLOT_W'(VOICES - 1)) ?
                              '0 : pick_slot + SLOT_W'(1);
               load_open_in = 1'b1;
               active_in[cur_slot] = 1'b0;
               pos_in[cur_slot]    = '0;
            end
            ram_wr_en = store_room;
            len_in[cur_slot] = len_new;
            if (last_ff) begin
               pos_in[cur_slot]    = '0;
               active_in[cur_slot] = len_new != '0;
               load_open_in        = 1'b0;
            end
            res_slot_in  = cur_slot;
            res_trunc_in = !store_room;
            state_in     = ST_DONE;
         end

         ST_CHECK: begin
            if (has_data) begin
               ram_rd_en = 1'b1;
               state_in  = ST_ADD;
            end else begin
               // Retire a voice that has nothing left, then advance, or finish after the last voice
               if (active_ff[cur_slot] && (cur_pos >= cur_len)) begin
                  active_in[cur_slot] = 1'b0;
               end
               if (last_voice) begin
                  state_in = ST_DONE;
               end else begin
                  voice_in = voice_ff + SLOT_W'(1);
               end
            end
         end

         ST_ADD: begin
            acc_ctl.add      = 1'b1;
            pos_in[cur_slot] = pos_next;
            if (pos_next >= cur_len) begin
               active_in[cur_slot] = 1'b0;
            end
            if (last_voice) begin
               state_in = ST_DONE;
            end else begin
               voice_in = voice_ff + SLOT_W'(1);
               state_in = ST_CHECK;
            end
         end

         ST_DONE: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = (cmd_ff == CMD_TICK) ? KIND_FRAME : KIND_ACK;
               rsp_mixed_in = (cmd_ff == CMD_TICK) ? acc_value : '0;
               rsp_slot_in  = SLOT_OUT_W'(res_slot_ff);
               rsp_trunc_in = res_trunc_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < VOICES; i++) begin
            len_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
         active_ff    <= '0;
         next_slot_ff <= '0;
         load_open_ff <= 1'b0;
         load_slot_ff <= '0;
         voice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         active_ff    <= active_in;
         next_slot_ff <= next_slot_in;
         load_open_ff <= load_open_in;
         load_slot_ff <= load_slot_in;
         voice_ff     <= voice_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      res_slot_ff  <= res_slot_in;
      res_trunc_ff <= res_trunc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_mixed_ff <= rsp_mixed_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   // ------------------------------------------------------------ units
   psm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   psm_accum u_accum (
      .clock  (clock),
      .ctl    (acc_ctl),
      .sample (ram_rd_data),
      .acc    (acc_value)
   );

   // ------------------------------------------------------------ ports
   assign req_chan.ready     = state_ff == ST_IDLE;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_kind_ff;
   assign rsp_chan.mixed     = rsp_mixed_ff;
   assign rsp_chan.slot      = rsp_slot_ff;
   assign rsp_chan.truncated = rsp_trunc_ff;

`ifndef ASSERT_OFF
   a_loading_voice_silent: assert property (@(posedge clock) disable iff (reset)
      load_open_ff |-> !active_ff[load_slot_ff])
      else $error("voice being loaded is sounding");

   a_active_has_samples: assert property (@(posedge clock) disable iff (reset)
      active_ff[voice_ff] |-> (pos_ff[voice_ff] < len_ff[voice_ff]))
      else $error("sounding voice has no samples left");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while an item is in work");

   a_frame_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_FRAME)) |->
      ((rsp_chan.mixed <= POS_ONE) && (rsp_chan.mixed >= NEG_ONE)))
      else $error("mixed frame outside clamp limits");

   a_ack_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_ACK)) |-> (rsp_chan.mixed == '0))
      else $error("load acknowledge carries a mix value");
`endif

endmodule
